[src/wlrl_pkg.sv]
// Package for the wear-leveled record log: job and result types, command codes,
// sequencer step codes and the CRC-8 helpers.
// No dependencies.
package wlrl_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned RECORD_SLOTS_DEF = 254;
  localparam int unsigned QUEUE_DEPTH_DEF  = 2;

  // CRC-8 definition: polynomial x^8+x^2+x+1, MSB first, no final xor
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Save keeps only locked, idle LED and dual cell bits
  localparam logic [7:0] FLAG_MASK = 8'h01 | 8'h02 | 8'h04;

  // Page base addresses, upper page erased first
  localparam logic [9:0] PAGE_HI_ADDR = 10'h200;
  localparam logic [9:0] PAGE_LO_ADDR = 10'h000;

  // Result command codes
  localparam logic [1:0] CMD_ERASE   = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_SKIP    = 2'd2;
  localparam logic [1:0] CMD_VERDICT = 2'd3;

  // Save sequencer steps: two erases, then four byte writes
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_ERASE_HI = 3'd0;
  localparam logic [STEP_W-1:0] STEP_ERASE_LO = 3'd1;
  localparam logic [STEP_W-1:0] STEP_BYTE0    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LAST     = 3'd5;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic       scan;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] flags;
    logic       force_req;
    logic [7:0] stored;
    logic [7:0] crc;
  } job_t;

  // One result item
  typedef struct packed {
    logic [1:0] command;
    logic [9:0] flash_address;
    logic [7:0] write_byte;
    logic       record_valid;
    logic       scan_done;
    logic       last;
  } out_item_t;

  // Bit-serial CRC over a 24-bit message; used with constant arguments only
  function automatic logic [7:0] crc8_serial(input logic [7:0] init, input logic [23:0] msg);
    logic [7:0] c;
    int i;
    c = init;
    for (i = 23; i >= 0; i--) begin
      c = {c[6:0], 1'b0} ^ ((c[7] ^ msg[i]) ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  // CRC of three bytes as an xor of per-bit columns plus the init term
  function automatic logic [7:0] crc8_msg(input logic [23:0] msg);
    logic [7:0] acc;
    int i;
    acc = crc8_serial(CRC_INIT, 24'h000000);
    for (i = 0; i < 24; i++) begin
      if (msg[i]) begin
        acc = acc ^ crc8_serial(8'h00, 24'h000001 << i);
      end
    end
    return acc;
  endfunction

endpackage

[src/wear_leveled_record_log.sv]
// An accepted item goes through the job queue and the result register to the port.
// Throughput: one result per cycle unless the output stalls; a scan or skipped save
// gives one result, a save four, a forced or log-full save six, all from one register.
// Input accepts while the two-entry job queue has room, also during a stalled output.
// Reset (synchronous, rst_n low) zeroes write slot, last CRC and scan state; no sweep.
module wear_leveled_record_log #(
  parameter int unsigned RECORD_SLOTS = wlrl_pkg::RECORD_SLOTS_DEF,
  parameter int unsigned QUEUE_DEPTH  = wlrl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic signed [15:0] in_ramp_current,
  input  logic        [7:0]  in_flag_byte,
  input  logic               in_force_req,
  input  logic        [7:0]  in_stored_checksum,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [1:0]  out_command,
  output logic        [9:0]  out_flash_address,
  output logic        [7:0]  out_write_byte,
  output logic               out_record_valid,
  output logic               out_scan_done,
  output logic               out_last
);
  import wlrl_pkg::*;

  job_t push_job, head_job;
  logic push, full, pop, head_valid;

  // Accept and classify
  wlrl_front u_front (
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_ramp_current    (in_ramp_current),
    .in_flag_byte       (in_flag_byte),
    .in_force_req       (in_force_req),
    .in_stored_checksum (in_stored_checksum),
    .q_full             (full),
    .q_push             (push),
    .q_job              (push_job)
  );

  // Decouple front and back
  wlrl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Carry out scans and saves
  wlrl_back #(
    .RECORD_SLOTS (RECORD_SLOTS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head_job          (head_job),
    .q_pop             (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_command       (out_command),
    .out_flash_address (out_flash_address),
    .out_write_byte    (out_write_byte),
    .out_record_valid  (out_record_valid),
    .out_scan_done     (out_scan_done),
    .out_last          (out_last)
  );

endmodule

[src/wlrl_front.sv]
// Front end of the record log: accepts items, masks save flags and computes CRC-8.
// Depends on wlrl_pkg.
module wlrl_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic signed [15:0] in_ramp_current,
  input  logic        [7:0]  in_flag_byte,
  input  logic               in_force_req,
  input  logic        [7:0]  in_stored_checksum,
  input  logic               q_full,
  output logic               q_push,
  output wlrl_pkg::job_t     q_job
);
  import wlrl_pkg::*;

  logic [7:0] flags_used;

  // Stall while the queue has no room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify: a scan checks all flag bits, a save keeps the low three
  assign flags_used = in_action ? in_flag_byte : (in_flag_byte & FLAG_MASK);

  always_comb begin
    q_job.scan      = in_action;
    q_job.hi        = in_ramp_current[15:8];
    q_job.lo        = in_ramp_current[7:0];
    q_job.flags     = flags_used;
    q_job.force_req = in_force_req;
    q_job.stored    = in_stored_checksum;
    q_job.crc       = crc8_msg({in_ramp_current[15:8], in_ramp_current[7:0], flags_used});
  end

endmodule

[src/wlrl_queue.sv]
// Short job queue between the front and back of the record log.
// Depends on wlrl_pkg.
module wlrl_queue #(
  parameter int unsigned DEPTH = wlrl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wlrl_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output wlrl_pkg::job_t head_job
);
  import wlrl_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slots_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[src/wlrl_back.sv]
// Back end of the record log: holds slot, CRC and scan state, sequences erase and
// write commands and drives the registered result port. Depends on wlrl_pkg.
module wlrl_back #(
  parameter int unsigned RECORD_SLOTS = wlrl_pkg::RECORD_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  wlrl_pkg::job_t head_job,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_command,
  output logic [9:0]     out_flash_address,
  output logic [7:0]     out_write_byte,
  output logic           out_record_valid,
  output logic           out_scan_done,
  output logic           out_last
);
  import wlrl_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_WRITE = 1'b1;

  logic              st_r, st_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [7:0]        write_slot_r, write_slot_nxt;
  logic [7:0]        last_crc_r, last_crc_nxt;
  logic [7:0]        scan_count_r, scan_count_nxt;
  logic              scan_stopped_r, scan_stopped_nxt;
  logic [7:0]        hi_r, lo_r, flags_r, crc_r, slot_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r;

  logic              adv, busy;
  logic              erase_c, skip_c, scan_ok_c, stop_c;
  logic [7:0]        slot_c, cnt_inc_c;
  logic [STEP_W-1:0] first_c;
  logic [STEP_W-1:0] sel_step;
  logic [7:0]        sel_hi, sel_lo, sel_flags, sel_crc, sel_slot;
  logic [1:0]        byte_idx;
  out_item_t         item;

  assign adv  = !out_valid_r || !out_stall;
  assign busy = (st_r == ST_WRITE);

  // Classify the head job against the current state
  always_comb begin
    erase_c   = head_job.force_req || (write_slot_r >= 8'(RECORD_SLOTS));
    slot_c    = erase_c ? 8'h00 : write_slot_r;
    first_c   = erase_c ? STEP_ERASE_HI : STEP_BYTE0;
    skip_c    = !head_job.force_req && (head_job.crc == last_crc_r);
    scan_ok_c = !scan_stopped_r && (head_job.crc == head_job.stored);
    cnt_inc_c = scan_count_r + 8'd1;
    stop_c    = scan_stopped_r || !scan_ok_c || (cnt_inc_c >= 8'(RECORD_SLOTS));
  end

  // Pick the record being sequenced: held one, or the head job on its first item
  always_comb begin
    if (busy) begin
      sel_step  = step_r;
      sel_hi    = hi_r;
      sel_lo    = lo_r;
      sel_flags = flags_r;
      sel_crc   = crc_r;
      sel_slot  = slot_r;
    end else begin
      sel_step  = first_c;
      sel_hi    = head_job.hi;
      sel_lo    = head_job.lo;
      sel_flags = head_job.flags;
      sel_crc   = head_job.crc;
      sel_slot  = slot_c;
    end
    byte_idx = 2'(sel_step - STEP_BYTE0);
  end

  // Build the next result item
  always_comb begin
    item = '0;
    if (!busy && head_job.scan) begin
      item.command      = CMD_VERDICT;
      item.record_valid = scan_ok_c;
      item.scan_done    = stop_c;
      item.last         = 1'b1;
    end else if (!busy && skip_c) begin
      item.command = CMD_SKIP;
      item.last    = 1'b1;
    end else begin
      unique case (sel_step)
        STEP_ERASE_HI: begin
          item.command       = CMD_ERASE;
          item.flash_address = PAGE_HI_ADDR;
        end
        STEP_ERASE_LO: begin
          item.command       = CMD_ERASE;
          item.flash_address = PAGE_LO_ADDR;
        end
        default: begin
          item.command       = CMD_WRITE;
          item.flash_address = {sel_slot, byte_idx};
          unique case (byte_idx)
            2'd0:    item.write_byte = sel_hi;
            2'd1:    item.write_byte = sel_lo;
            2'd2:    item.write_byte = sel_flags;
            default: item.write_byte = sel_crc;
          endcase
          item.last = (sel_step == STEP_LAST);
        end
      endcase
    end
  end

  // Advance the sequencer and the log state
  always_comb begin
    st_nxt           = st_r;
    step_nxt         = step_r;
    write_slot_nxt   = write_slot_r;
    last_crc_nxt     = last_crc_r;
    scan_count_nxt   = scan_count_r;
    scan_stopped_nxt = scan_stopped_r;
    out_valid_nxt    = out_valid_r;
    q_pop            = 1'b0;
    if (adv) begin
      out_valid_nxt = busy || head_valid;
      if (busy) begin
        if (step_r == STEP_LAST) begin
          st_nxt = ST_IDLE;
        end
        step_nxt = step_r + 1'b1;
      end else if (head_valid) begin
        q_pop = 1'b1;
        if (head_job.scan) begin
          if (scan_ok_c) begin
            scan_count_nxt = cnt_inc_c;
            write_slot_nxt = cnt_inc_c;
            last_crc_nxt   = head_job.stored;
          end
          scan_stopped_nxt = stop_c;
        end else if (!skip_c) begin
          write_slot_nxt = slot_c + 8'd1;
          last_crc_nxt   = head_job.crc;
          st_nxt         = ST_WRITE;
          step_nxt       = first_c + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= ST_IDLE;
      step_r         <= '0;
      write_slot_r   <= '0;
      last_crc_r     <= '0;
      scan_count_r   <= '0;
      scan_stopped_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      st_r           <= st_nxt;
      step_r         <= step_nxt;
      write_slot_r   <= write_slot_nxt;
      last_crc_r     <= last_crc_nxt;
      scan_count_r   <= scan_count_nxt;
      scan_stopped_r <= scan_stopped_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Hold the record for the rest of its sequence
  always_ff @(posedge clk) begin
    if (adv && !busy && head_valid) begin
      hi_r    <= head_job.hi;
      lo_r    <= head_job.lo;
      flags_r <= head_job.flags;
      crc_r   <= head_job.crc;
      slot_r  <= slot_c;
    end
  end

  // Load the result register when the port moves
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= item;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_command       = out_r.command;
  assign out_flash_address = out_r.flash_address;
  assign out_write_byte    = out_r.write_byte;
  assign out_record_valid  = out_r.record_valid;
  assign out_scan_done     = out_r.scan_done;
  assign out_last          = out_r.last;

  // Verdicts and skips always close their item
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.command == CMD_VERDICT || out_r.command == CMD_SKIP) |-> out_r.last)
    else $error("verdict or skip result without last");

  // Write slot never passes the slot limit
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    write_slot_r <= 8'(RECORD_SLOTS))
    else $error("write slot beyond slot limit");

  // A stopped scan stays stopped until reset
  a_scan_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    scan_stopped_r |=> scan_stopped_r)
    else $error("scan restarted without reset");

  // Byte writes land inside the slot range
  a_write_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.command == CMD_WRITE |-> out_r.flash_address[9:2] < 8'(RECORD_SLOTS))
    else $error("byte write outside record slots");

  // The sequencer only runs mid-save, never on its first step
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> step_r != STEP_ERASE_HI && out_valid_r)
    else $error("save sequencer in impossible step");

endmodule

[bench/wlrl_tb_pkg.sv]
// Bench-side definitions for the record log: action codes and the record CRC.
// Depends on wlrl_pkg for the CRC polynomial and initial value.
package wlrl_tb_pkg;

  localparam logic ACT_SAVE = 1'b0;
  localparam logic ACT_SCAN = 1'b1;

  // CRC-8 over ramp high byte, ramp low byte and flags, shifted MSB first
  function automatic logic [7:0] record_crc(input logic [15:0] ramp, input logic [7:0] flags);
    logic [23:0] msg;
    logic [7:0]  c;
    int          b;
    msg = {ramp, flags};
    c = wlrl_pkg::CRC_INIT;
    for (b = 23; b >= 0; b--) begin
      if (c[7] ^ msg[b]) begin
        c = {c[6:0], 1'b0} ^ wlrl_pkg::CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[bench/wlrl_checker.sv]
// Checker for the record log: watches both channels, predicts the flash
// operations of each accepted item and compares them in order.
// Depends on wlrl_pkg and wlrl_tb_pkg.
module wlrl_checker #(
  parameter int SLOTS = 254
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  logic [15:0] in_ramp_current,
  input  logic [7:0]  in_flag_byte,
  input  logic        in_force_req,
  input  logic [7:0]  in_stored_checksum,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_command,
  input  logic [9:0]  out_flash_address,
  input  logic [7:0]  out_write_byte,
  input  logic        out_record_valid,
  input  logic        out_scan_done,
  input  logic        out_last,
  output int          mismatch_count,
  output int          ops_pending,
  output int          ops_checked,
  output int          boot_accepts,
  output int          skip_count,
  output int          erase_pairs
);
  timeunit 1ns;
  timeprecision 1ps;
  import wlrl_pkg::*;
  import wlrl_tb_pkg::*;

  logic [7:0] slot_next;
  logic [7:0] crc_last;
  logic [7:0] boot_count;
  logic       boot_over;
  out_item_t  flash_ops_due [$];

  // Advance the log state for one item and queue the operations it causes
  task automatic predict_flash_ops(input logic act, input logic [15:0] ramp,
                                   input logic [7:0] flags, input logic frc,
                                   input logic [7:0] stored);
    out_item_t   op;
    logic [7:0]  crc;
    logic [7:0]  kept;
    logic [31:0] rec_word;
    int          k;
    op = '0;
    if (act == ACT_SCAN) begin
      op.command = CMD_VERDICT;
      op.last = 1'b1;
      if (!boot_over) begin
        crc = record_crc(ramp, flags);
        if (crc == stored) begin
          op.record_valid = 1'b1;
          boot_count = boot_count + 8'd1;
          slot_next = boot_count;
          crc_last = stored;
          boot_accepts++;
          if (int'(boot_count) >= SLOTS) begin
            boot_over = 1'b1;
          end
        end else begin
          boot_over = 1'b1;
        end
      end
      op.scan_done = boot_over;
      flash_ops_due.push_back(op);
    end else begin
      kept = flags & FLAG_MASK;
      crc = record_crc(ramp, kept);
      if (!frc && crc == crc_last) begin
        op.command = CMD_SKIP;
        op.last = 1'b1;
        flash_ops_due.push_back(op);
        skip_count++;
      end else begin
        // Forced save or full log: wipe both pages, restart at slot 0
        if (frc || int'(slot_next) >= SLOTS) begin
          op.command = CMD_ERASE;
          op.flash_address = PAGE_HI_ADDR;
          flash_ops_due.push_back(op);
          op.flash_address = PAGE_LO_ADDR;
          flash_ops_due.push_back(op);
          slot_next = '0;
          erase_pairs++;
        end
        rec_word = {ramp, kept, crc};
        for (k = 0; k < 4; k++) begin
          op = '0;
          op.command = CMD_WRITE;
          op.flash_address = 10'({slot_next, 2'b00} + k);
          op.write_byte = rec_word[31 - 8 * k -: 8];
          op.last = (k == 3);
          flash_ops_due.push_back(op);
        end
        slot_next = slot_next + 8'd1;
        crc_last = crc;
      end
    end
  endtask

  // Predict on input accepts, compare on output accepts
  always @(posedge clk) begin : track
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      slot_next = '0;
      crc_last = '0;
      boot_count = '0;
      boot_over = 1'b0;
      flash_ops_due.delete();
      mismatch_count = 0;
      ops_checked = 0;
      boot_accepts = 0;
      skip_count = 0;
      erase_pairs = 0;
      ops_pending <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_flash_ops(in_action, in_ramp_current, in_flag_byte, in_force_req,
                          in_stored_checksum);
      end
      if (out_valid && !out_stall) begin
        got = {out_command, out_flash_address, out_write_byte, out_record_valid,
               out_scan_done, out_last};
        ops_checked++;
        if (flash_ops_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("checker: unexpected item cmd %0d addr %0h byte %0h v%0b d%0b l%0b",
                     got.command, got.flash_address, got.write_byte,
                     got.record_valid, got.scan_done, got.last);
          end
        end else begin
          want = flash_ops_due.pop_front();
          if (got != want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("checker: item %0d expected cmd %0d addr %0h byte %0h v%0b d%0b l%0b",
                       ops_checked, want.command, want.flash_address, want.write_byte,
                       want.record_valid, want.scan_done, want.last);
              $display("checker: item %0d got      cmd %0d addr %0h byte %0h v%0b d%0b l%0b",
                       ops_checked, got.command, got.flash_address, got.write_byte,
                       got.record_valid, got.scan_done, got.last);
            end
          end
        end
      end
      ops_pending <= flash_ops_due.size();
    end
  end

endmodule

[bench/tb.sv]
// Top of the record log bench: clock, reset, item stimulus and result-side stalls.
// Depends on wlrl_pkg, wlrl_tb_pkg, wlrl_checker and the wear_leveled_record_log RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wlrl_tb_pkg::*;

  localparam int PERIOD      = 8;
  localparam int SLOTS       = wlrl_pkg::RECORD_SLOTS_DEF;
  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 64;
  localparam int TAIL_CYCLES = 20;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_action;
  logic signed [15:0] in_ramp_current;
  logic        [7:0]  in_flag_byte;
  logic               in_force_req;
  logic        [7:0]  in_stored_checksum;
  logic               out_valid;
  logic               out_stall;
  logic        [1:0]  out_command;
  logic        [9:0]  out_flash_address;
  logic        [7:0]  out_write_byte;
  logic               out_record_valid;
  logic               out_scan_done;
  logic               out_last;

  logic        hold_req;
  logic        hold_done;
  logic        quiet;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          scans_sent = 0;
  logic [15:0] last_ramp = '0;
  logic [7:0]  last_flags = '0;

  int mismatch_count, ops_pending, ops_checked, boot_accepts, skip_count, erase_pairs;

  always #(PERIOD / 2) clk = ~clk;

  wear_leveled_record_log #(
    .RECORD_SLOTS(SLOTS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_ramp_current(in_ramp_current), .in_flag_byte(in_flag_byte),
    .in_force_req(in_force_req), .in_stored_checksum(in_stored_checksum),
    .out_valid(out_valid), .out_stall(out_stall), .out_command(out_command),
    .out_flash_address(out_flash_address), .out_write_byte(out_write_byte),
    .out_record_valid(out_record_valid), .out_scan_done(out_scan_done),
    .out_last(out_last)
  );

  wlrl_checker #(
    .SLOTS(SLOTS)
  ) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_ramp_current(in_ramp_current), .in_flag_byte(in_flag_byte),
    .in_force_req(in_force_req), .in_stored_checksum(in_stored_checksum),
    .out_valid(out_valid), .out_stall(out_stall), .out_command(out_command),
    .out_flash_address(out_flash_address), .out_write_byte(out_write_byte),
    .out_record_valid(out_record_valid), .out_scan_done(out_scan_done),
    .out_last(out_last),
    .mismatch_count(mismatch_count), .ops_pending(ops_pending),
    .ops_checked(ops_checked), .boot_accepts(boot_accepts),
    .skip_count(skip_count), .erase_pairs(erase_pairs)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Offer one item, hold it until accepted, then maybe go idle for a burst
  task automatic send(input logic act, input logic [15:0] ramp, input logic [7:0] flags,
                      input logic frc, input logic [7:0] stored);
    in_valid <= 1'b1;
    in_action <= act;
    in_ramp_current <= ramp;
    in_flag_byte <= flags;
    in_force_req <= frc;
    in_stored_checksum <= stored;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (act == ACT_SAVE) begin
      last_ramp = ramp;
      last_flags = flags;
    end
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Present a stored record with a matching checksum
  task automatic send_scan(input logic [15:0] ramp, input logic [7:0] flags);
    send(ACT_SCAN, ramp, flags, 1'($urandom_range(0, 1)), record_crc(ramp, flags));
    scans_sent++;
  endtask

  // Stop offering until every predicted operation has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (ops_pending != 0);
  endtask

  function automatic logic [15:0] pick_ramp();
    case ($urandom_range(0, 11))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Result side: random stall bursts, one long hold on request, none at the end
  initial begin : receiver
    int run;
    out_stall <= 1'b0;
    hold_done <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_done <= 1'b1;
        while (hold_req) @(posedge clk);
        hold_done <= 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        run = $urandom_range(1, 16);
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (run - 1) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [15:0] ramp;
    logic [7:0]  flags;
    logic [15:0] zero_ramp;
    int          k;
    int          pick;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_SAVE;
    in_ramp_current <= '0;
    in_flag_byte <= '0;
    in_force_req <= 1'b0;
    in_stored_checksum <= '0;
    hold_req <= 1'b0;
    quiet <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Find a record whose CRC equals the reset value of the last CRC
    zero_ramp = '0;
    for (k = 0; k < 65536; k++) begin
      if (record_crc(16'(k), 8'h00) == 8'h00) begin
        zero_ramp = 16'(k);
        break;
      end
    end

    // Directed: skip straight out of reset, boot records at the extremes,
    // saves during the scan, flag masking, forced rewrite
    send(ACT_SAVE, zero_ramp, 8'h00, 1'b0, 8'hFF);
    send_scan(16'h7FFF, 8'hFF);
    send_scan(16'h8000, 8'h00);
    send_scan(16'h0000, 8'h80);
    send_scan(16'hFFFF, 8'h55);
    send(ACT_SAVE, 16'h7FFF, 8'hFF, 1'b0, 8'h00);
    send(ACT_SAVE, 16'h7FFF, 8'h07, 1'b0, 8'hFF);
    send(ACT_SAVE, 16'h7FFF, 8'h07, 1'b1, 8'hAA);
    send(ACT_SAVE, 16'h8000, 8'hF8, 1'b0, 8'h00);
    send_scan(16'h1234, 8'hAA);
    send(ACT_SAVE, 16'h0001, 8'h02, 1'b0, 8'h55);
    drain();

    // Boot scan of well-formed records up to the slot limit, saves mixed in
    while (scans_sent < SLOTS) begin
      if ($urandom_range(0, 7) == 0) begin
        send(ACT_SAVE, pick_ramp(), 8'($urandom), ($urandom_range(0, 7) == 0),
             8'($urandom));
      end else begin
        send_scan(pick_ramp(), 8'($urandom));
      end
    end
    drain();

    // Log is now full: the next save wipes it; later scans are ignored
    send(ACT_SAVE, pick_ramp(), 8'($urandom), 1'b0, 8'($urandom));
    send(ACT_SCAN, 16'h1234, 8'hAA, 1'b0, record_crc(16'h1234, 8'hAA));

    // Random saves, repeats and stray scans
    for (k = 0; k < 170; k++) begin
      if (k == 50) begin
        // Hold the result side while forced saves keep coming
        hold_req <= 1'b1;
        repeat (8) send(ACT_SAVE, pick_ramp(), 8'($urandom), 1'b1, 8'($urandom));
        while (!hold_done) @(posedge clk);
        hold_req <= 1'b0;
        drain();
      end
      if (k == 110) begin
        drain();
      end
      if (k == 130) begin
        quiet <= 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        ramp = pick_ramp();
        flags = 8'($urandom);
        send(ACT_SCAN, ramp, flags, 1'($urandom_range(0, 1)),
             $urandom_range(0, 1) ? record_crc(ramp, flags) : 8'($urandom));
      end else if (pick <= 2) begin
        send(ACT_SAVE, last_ramp, last_flags ^ (8'($urandom) & ~wlrl_pkg::FLAG_MASK),
             1'b0, 8'($urandom));
      end else begin
        send(ACT_SAVE, pick_ramp(), 8'($urandom), (pick == 3), 8'($urandom));
      end
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d items offered, %0d flash operations checked", items_sent,
             ops_checked);
    $display("summary: %0d boot records taken, %0d unchanged saves, %0d page wipes",
             boot_accepts, skip_count, erase_pairs);
    if (mismatch_count == 0 && ops_pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
